// ----- hw/rtl/cs64_pkg.sv -----
// ----------------------------------------------------------------------------
// cs64_pkg
// Shared types, control word layout and the microprogram of the dual-chain
// keyed hash.
// ----------------------------------------------------------------------------
package cs64_pkg;

    localparam int WORD_W = 32;
    localparam int HASH_W = 64;
    localparam int STEP_W = 5;

    typedef logic [STEP_W-1:0] step_t;

    // configuration register indexes
    localparam logic CFG_KEY0 = 1'b0;
    localparam logic CFG_KEY1 = 1'b1;

    // microprogram entry points
    localparam step_t STEP_IDLE = 5'd0;
    localparam step_t STEP_EVEN = 5'd1;
    localparam step_t STEP_ODD  = 5'd13;
    localparam step_t STEP_FIN  = 5'd25;

    // key offsets of the word-swap chain
    localparam logic [WORD_W-1:0] SWAP_EVEN_OFS = 32'h69FB0000;
    localparam logic [WORD_W-1:0] SWAP_ODD_OFS  = 32'h13DB0000;

    typedef enum logic [1:0] {
        OP_NOP,
        OP_LOAD,   // t = base + word
        OP_MUL,    // prod = m * t
        OP_ACC     // t = prod +/- c * (t >> 16)
    } op_t;

    typedef enum logic [1:0] {
        WB_NONE,
        WB_EVEN,   // store half values, move to odd position
        WB_ODD,    // store chain values and sums, mark a pair
        WB_FIN     // emit result, clear message state
    } wb_t;

    typedef enum logic [2:0] {
        COND_NEXT,
        COND_DISPATCH,
        COND_END,
        COND_FIN,
        COND_IDLE
    } cond_t;

    typedef struct packed {
        logic              en;
        logic              sub;
        logic              key;   // add the selected key (forced odd) to m
        logic [WORD_W-1:0] m;
        logic [WORD_W-1:0] c;
    } lane_ctrl_t;

    typedef struct packed {
        op_t        op;
        lane_ctrl_t s;     // word-swap chain
        lane_ctrl_t r;     // reversible chain
        wb_t        wb;
        cond_t      cond;
    } ctrl_t;

    typedef struct packed {
        logic odd;        // next word sits at an odd position
        logic out_free;   // output register can take a result this cycle
    } dp_status_t;

    localparam lane_ctrl_t LANE_OFF = '{en: 1'b0, sub: 1'b0, key: 1'b0,
                                       m: 32'h0, c: 32'h0};

    function automatic lane_ctrl_t lc(input logic a_en, input logic a_sub,
                                      input logic a_key,
                                      input logic [WORD_W-1:0] a_m,
                                      input logic [WORD_W-1:0] a_c);
        lane_ctrl_t v;
        v.en  = a_en;
        v.sub = a_sub;
        v.key = a_key;
        v.m   = a_m;
        v.c   = a_c;
        return v;
    endfunction

    function automatic ctrl_t cw(input op_t a_op, input lane_ctrl_t a_s,
                                 input lane_ctrl_t a_r, input wb_t a_wb,
                                 input cond_t a_cond);
        ctrl_t v;
        v.op   = a_op;
        v.s    = a_s;
        v.r    = a_r;
        v.wb   = a_wb;
        v.cond = a_cond;
        return v;
    endfunction

    // Microprogram. MUL/ACC pairs form one mix step; a lane with en low holds.
    function automatic ctrl_t cs64_rom(input step_t pc);
        ctrl_t v;
        unique case (pc)
            // idle: wait for a word and branch on position / last marker
            5'd0:  v = cw(OP_NOP, LANE_OFF, LANE_OFF, WB_NONE, COND_DISPATCH);
            // even-position word
            5'd1:  v = cw(OP_LOAD, lc(1'b1, 1'b0, 1'b0, 32'h0, 32'h0),
                          lc(1'b1, 1'b0, 1'b0, 32'h0, 32'h0), WB_NONE, COND_NEXT);
            5'd2:  v = cw(OP_MUL, lc(1'b1, 1'b0, 1'b1, SWAP_EVEN_OFS, 32'h0),
                          lc(1'b1, 1'b0, 1'b1, 32'h0, 32'h0), WB_NONE, COND_NEXT);
            5'd3:  v = cw(OP_ACC, lc(1'b1, 1'b1, 1'b0, 32'h0, 32'h10FA9605),
                          lc(1'b1, 1'b0, 1'b0, 32'h0, 32'h0), WB_NONE, COND_NEXT);
            5'd4:  v = cw(OP_MUL, lc(1'b1, 1'b0, 1'b0, 32'h79F8A395, 32'h0),
                          lc(1'b1, 1'b0, 1'b0, 32'hB1110000, 32'h0), WB_NONE, COND_NEXT);
            5'd5:  v = cw(OP_ACC, lc(1'b1, 1'b0, 1'b0, 32'h0, 32'h689B6B9F),
                          lc(1'b1, 1'b1, 1'b0, 32'h0, 32'h30674EEF), WB_NONE, COND_NEXT);
            5'd6:  v = cw(OP_MUL, lc(1'b1, 1'b0, 1'b0, 32'hEA970001, 32'h0),
                          lc(1'b1, 1'b0, 1'b0, 32'h5B9F0000, 32'h0), WB_NONE, COND_NEXT);
            5'd7:  v = cw(OP_ACC, lc(1'b1, 1'b1, 1'b0, 32'h0, 32'h3C101569),
                          lc(1'b1, 1'b1, 1'b0, 32'h0, 32'h78F7A461), WB_NONE, COND_NEXT);
            5'd8:  v = cw(OP_MUL, LANE_OFF,
                          lc(1'b1, 1'b0, 1'b0, 32'hB96D0000, 32'h0), WB_NONE, COND_NEXT);
            5'd9:  v = cw(OP_ACC, LANE_OFF,
                          lc(1'b1, 1'b0, 1'b0, 32'h0, 32'h12CEB96D), WB_NONE, COND_NEXT);
            5'd10: v = cw(OP_MUL, LANE_OFF,
                          lc(1'b1, 1'b0, 1'b0, 32'h1D830000, 32'h0), WB_NONE, COND_NEXT);
            5'd11: v = cw(OP_ACC, LANE_OFF,
                          lc(1'b1, 1'b0, 1'b0, 32'h0, 32'h257E1D83), WB_NONE, COND_NEXT);
            5'd12: v = cw(OP_NOP, LANE_OFF, LANE_OFF, WB_EVEN, COND_IDLE);
            // odd-position word
            5'd13: v = cw(OP_LOAD, lc(1'b1, 1'b0, 1'b0, 32'h0, 32'h0),
                          lc(1'b1, 1'b0, 1'b0, 32'h0, 32'h0), WB_NONE, COND_NEXT);
            5'd14: v = cw(OP_MUL, lc(1'b1, 1'b0, 1'b1, SWAP_ODD_OFS, 32'h0),
                          lc(1'b1, 1'b0, 1'b1, 32'h0, 32'h0), WB_NONE, COND_NEXT);
            5'd15: v = cw(OP_ACC, lc(1'b1, 1'b1, 1'b0, 32'h0, 32'h3CE8EC25),
                          lc(1'b1, 1'b0, 1'b0, 32'h0, 32'h0), WB_NONE, COND_NEXT);
            5'd16: v = cw(OP_MUL, lc(1'b1, 1'b0, 1'b0, 32'h59C3AF2D, 32'h0),
                          lc(1'b1, 1'b0, 1'b0, 32'h16F50000, 32'h0), WB_NONE, COND_NEXT);
            5'd17: v = cw(OP_ACC, lc(1'b1, 1'b1, 1'b0, 32'h0, 32'h2232E0F1),
                          lc(1'b1, 1'b1, 1'b0, 32'h0, 32'h5D8BE90B), WB_NONE, COND_NEXT);
            5'd18: v = cw(OP_MUL, lc(1'b1, 1'b0, 1'b0, 32'h1EC90001, 32'h0),
                          lc(1'b1, 1'b0, 1'b0, 32'h96FF0000, 32'h0), WB_NONE, COND_NEXT);
            5'd19: v = cw(OP_ACC, lc(1'b1, 1'b0, 1'b0, 32'h0, 32'h35BD1EC9),
                          lc(1'b1, 1'b1, 1'b0, 32'h0, 32'h2C7C6901), WB_NONE, COND_NEXT);
            5'd20: v = cw(OP_MUL, LANE_OFF,
                          lc(1'b1, 1'b0, 1'b0, 32'h2B890000, 32'h0), WB_NONE, COND_NEXT);
            5'd21: v = cw(OP_ACC, LANE_OFF,
                          lc(1'b1, 1'b0, 1'b0, 32'h0, 32'h7C932B89), WB_NONE, COND_NEXT);
            5'd22: v = cw(OP_MUL, LANE_OFF,
                          lc(1'b1, 1'b0, 1'b0, 32'h9F690000, 32'h0), WB_NONE, COND_NEXT);
            5'd23: v = cw(OP_ACC, LANE_OFF,
                          lc(1'b1, 1'b1, 1'b0, 32'h0, 32'h405B6097), WB_NONE, COND_NEXT);
            5'd24: v = cw(OP_NOP, LANE_OFF, LANE_OFF, WB_ODD, COND_END);
            // emit result once the output register is free
            5'd25: v = cw(OP_NOP, LANE_OFF, LANE_OFF, WB_FIN, COND_FIN);
            default: v = cw(OP_NOP, LANE_OFF, LANE_OFF, WB_NONE, COND_IDLE);
        endcase
        return v;
    endfunction

endpackage

// ----- hw/rtl/cs64_lane.sv -----
// ----------------------------------------------------------------------------
// cs64_lane
// One hash chain lane: working value, product register and the multipliers for m * t and c * (t >> 16).
// ----------------------------------------------------------------------------
module cs64_lane (
    input  logic                        clk,
    input  cs64_pkg::op_t               op,
    input  cs64_pkg::lane_ctrl_t        lctl,
    input  logic [cs64_pkg::WORD_W-1:0] base,
    input  logic [cs64_pkg::WORD_W-1:0] word,
    input  logic [cs64_pkg::WORD_W-1:0] key,
    output logic [cs64_pkg::WORD_W-1:0] t
);

    logic [cs64_pkg::WORD_W-1:0]   t_reg, t_next;
    logic [cs64_pkg::WORD_W-1:0]   prod_reg, prod_next;
    logic [cs64_pkg::WORD_W-1:0]   m_eff;
    logic [cs64_pkg::WORD_W-1:0]   prod_lo;
    logic [cs64_pkg::WORD_W-1:0]   cq;

    // only the low 32 bits of each product are kept
    assign m_eff   = lctl.m + (lctl.key ? key : '0);
    assign prod_lo = m_eff * t_reg;
    assign cq      = lctl.c * {16'h0, t_reg[31:16]};

    always_comb
    begin
        t_next    = t_reg;
        prod_next = prod_reg;
        case (op)
            cs64_pkg::OP_LOAD: t_next = base + word;
            cs64_pkg::OP_MUL:
            begin
                if (lctl.en)
                begin
                    prod_next = prod_lo;
                end
            end
            cs64_pkg::OP_ACC:
            begin
                if (lctl.en)
                begin
                    t_next = lctl.sub ? (prod_reg - cq) : (prod_reg + cq);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        t_reg    <= t_next;
        prod_reg <= prod_next;
    end

    assign t = t_reg;

endmodule

// ----- hw/rtl/cs64_seq.sv -----
// ----------------------------------------------------------------------------
// cs64_seq
// Microcode sequencer: step counter, control ROM and branch conditions.
// ----------------------------------------------------------------------------
module cs64_seq (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    input  logic                   s_tlast,
    output logic                   s_tready,
    input  cs64_pkg::dp_status_t   status,
    output cs64_pkg::ctrl_t        ctrl,
    output logic                   accept,
    output logic                   fin_go
);

    cs64_pkg::step_t pc_reg, pc_next;
    logic            last_reg, last_next;

    assign ctrl     = cs64_pkg::cs64_rom(pc_reg);
    assign s_tready = (pc_reg == cs64_pkg::STEP_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign fin_go   = (ctrl.wb == cs64_pkg::WB_FIN) && status.out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg   <= cs64_pkg::STEP_IDLE;
            last_reg <= 1'b0;
        end
        else
        begin
            pc_reg   <= pc_next;
            last_reg <= last_next;
        end
    end

    always_comb
    begin
        pc_next   = pc_reg;
        last_next = accept ? s_tlast : last_reg;
        unique case (ctrl.cond)
            cs64_pkg::COND_NEXT: pc_next = pc_reg + 1'b1;
            cs64_pkg::COND_DISPATCH:
            begin
                if (accept)
                begin
                    if (status.odd)
                        pc_next = cs64_pkg::STEP_ODD;
                    else if (s_tlast)
                        pc_next = cs64_pkg::STEP_FIN;   // lone trailing word
                    else
                        pc_next = cs64_pkg::STEP_EVEN;
                end
            end
            cs64_pkg::COND_END:
                pc_next = last_reg ? cs64_pkg::STEP_FIN : cs64_pkg::STEP_IDLE;
            cs64_pkg::COND_FIN:
                pc_next = status.out_free ? cs64_pkg::STEP_IDLE : pc_reg;
            cs64_pkg::COND_IDLE: pc_next = cs64_pkg::STEP_IDLE;
            default: pc_next = cs64_pkg::STEP_IDLE;
        endcase
    end

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (pc_reg != cs64_pkg::STEP_IDLE))
        else $error("accepted item did not start a program");

    a_fin_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (pc_reg == cs64_pkg::STEP_FIN) && !status.out_free
        |=> (pc_reg == cs64_pkg::STEP_FIN))
        else $error("finish step left while output busy");

    a_odd_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (pc_reg == cs64_pkg::STEP_ODD) |-> status.odd)
        else $error("odd program entered at even position");

endmodule

// ----- hw/rtl/cs64_dp.sv -----
// ----------------------------------------------------------------------------
// cs64_dp
// Datapath: key registers, word register, two chain lanes, message state and
// output register.
// ----------------------------------------------------------------------------
module cs64_dp (
    input  logic                        clk,
    input  logic                        rst_n,
    input  cs64_pkg::ctrl_t             ctrl,
    input  logic                        accept,
    input  logic                        fin_go,
    input  logic [cs64_pkg::WORD_W-1:0] word,
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [cs64_pkg::WORD_W-1:0] cfg_wdata,
    output cs64_pkg::dp_status_t        status,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [cs64_pkg::HASH_W-1:0] m_tdata,
    output logic                        m_tuser
);

    logic [cs64_pkg::WORD_W-1:0] key0_reg, key1_reg;
    logic [cs64_pkg::WORD_W-1:0] word_reg;
    logic [cs64_pkg::WORD_W-1:0] swap_val_reg, swap_sum_reg, swap_half_reg;
    logic [cs64_pkg::WORD_W-1:0] rev_val_reg, rev_sum_reg, rev_half_reg;
    logic                        odd_reg, pair_reg;
    logic                        out_valid_reg;
    logic [cs64_pkg::HASH_W-1:0] hash_reg;
    logic                        ok_reg;

    logic [cs64_pkg::WORD_W-1:0] key_eff, base_s, base_r, t_s, t_r;

    // key is forced odd; the position picks which one
    assign key_eff = (odd_reg ? key1_reg : key0_reg) | 32'h1;
    assign base_s  = odd_reg ? swap_half_reg : swap_val_reg;
    assign base_r  = odd_reg ? rev_half_reg  : rev_val_reg;

    cs64_lane u_swap (
        .clk  (clk),
        .op   (ctrl.op),
        .lctl (ctrl.s),
        .base (base_s),
        .word (word_reg),
        .key  (key_eff),
        .t    (t_s)
    );

    cs64_lane u_rev (
        .clk  (clk),
        .op   (ctrl.op),
        .lctl (ctrl.r),
        .base (base_r),
        .word (word_reg),
        .key  (key_eff),
        .t    (t_r)
    );

    always_ff @(posedge clk)
    begin
        if (accept)
            word_reg <= word;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key0_reg <= '0;
            key1_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                cs64_pkg::CFG_KEY0: key0_reg <= cfg_wdata;
                cs64_pkg::CFG_KEY1: key1_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            swap_val_reg  <= '0;
            swap_sum_reg  <= '0;
            swap_half_reg <= '0;
            rev_val_reg   <= '0;
            rev_sum_reg   <= '0;
            rev_half_reg  <= '0;
            odd_reg       <= 1'b0;
            pair_reg      <= 1'b0;
        end
        else
        begin
            case (ctrl.wb)
                cs64_pkg::WB_EVEN:
                begin
                    swap_half_reg <= t_s;
                    rev_half_reg  <= t_r;
                    odd_reg       <= 1'b1;
                end
                cs64_pkg::WB_ODD:
                begin
                    swap_val_reg <= t_s;
                    swap_sum_reg <= swap_half_reg + t_s + swap_sum_reg;
                    rev_val_reg  <= t_r;
                    rev_sum_reg  <= rev_half_reg + t_r + rev_sum_reg;
                    pair_reg     <= 1'b1;
                    odd_reg      <= 1'b0;
                end
                cs64_pkg::WB_FIN:
                begin
                    if (fin_go)
                    begin
                        swap_val_reg  <= '0;
                        swap_sum_reg  <= '0;
                        swap_half_reg <= '0;
                        rev_val_reg   <= '0;
                        rev_sum_reg   <= '0;
                        rev_half_reg  <= '0;
                        odd_reg       <= 1'b0;
                        pair_reg      <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (fin_go)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (fin_go)
        begin
            ok_reg   <= pair_reg;
            hash_reg <= pair_reg ? {swap_sum_reg ^ rev_sum_reg, swap_val_reg ^ rev_val_reg}
                                 : '0;
        end
    end

    assign status.odd      = odd_reg;
    assign status.out_free = !out_valid_reg || m_tready;
    assign m_tvalid        = out_valid_reg;
    assign m_tdata         = hash_reg;
    assign m_tuser         = ok_reg;

    a_fin_free: assert property (@(posedge clk) disable iff (!rst_n)
        fin_go |-> (!out_valid_reg || m_tready))
        else $error("result overwrote an untaken result");

    a_fin_clears: assert property (@(posedge clk) disable iff (!rst_n)
        fin_go |=> (out_valid_reg && !odd_reg && !pair_reg))
        else $error("finish did not post result and clear state");

    a_odd_wb: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.wb == cs64_pkg::WB_ODD) |-> odd_reg)
        else $error("odd write-back without a pending half");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !ok_reg) |-> (hash_reg == '0))
        else $error("failed result carries a non-zero hash");

endmodule

// ----- hw/rtl/cs64_dual_word_hash_unit.sv -----
// ----------------------------------------------------------------------------
// cs64_dual_word_hash_unit
// Keyed dual-chain multiply-shift message hash, run by a microcoded sequencer.
// ----------------------------------------------------------------------------
// Pacing: a word is taken only in the idle/dispatch step, ahead of a 12-step
//   microprogram, so a new word waits until the last one is through; a final
//   word at an odd position also runs the finish step, a lone final word goes
//   straight to it. The five dependent mix steps of the reversible chain set
//   this pace.
// Result: posted by the finish step, then held until the sink takes it.
// Reset: asynchronous, active low; keys, chain state and output valid clear.
// ----------------------------------------------------------------------------
module cs64_dual_word_hash_unit (
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // [31:0] data_word
    input  logic        s_tlast,    // last_word
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,    // [63:0] hash_value
    output logic        m_tuser,    // hash_ok
    // configuration: index 0 key_word0, index 1 key_word1
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_wdata
);

    cs64_pkg::ctrl_t      ctrl;
    cs64_pkg::dp_status_t status;
    logic                 accept;
    logic                 fin_go;

    // Sequencer: ROM word per step; branches on word position, last marker
    // and whether the output register can take the result.
    cs64_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .status   (status),
        .ctrl     (ctrl),
        .accept   (accept),
        .fin_go   (fin_go)
    );

    // Datapath: both chains run in lockstep on the same control word; the
    // word-swap lane sits out the steps the reversible chain needs extra.
    cs64_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .accept    (accept),
        .fin_go    (fin_go),
        .word      (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule
